/* hdl/wsc_pkg.sv */
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants of the wave sound channel
// Item structs, opcodes, register addresses, readback masks and field widths.
// ----------------------------------------------------------------------------
package wsc_pkg;

	// Field and state widths
	localparam int OPCODE_W   = 3;
	localparam int ADDR_W     = 16;
	localparam int SLOT_W     = 4;
	localparam int BYTE_W     = 8;
	localparam int CYCLE_W    = 16;
	localparam int FREQ_W     = 11;
	localparam int SHIFT_W    = 4;
	localparam int LEN_W      = 24;
	localparam int PHASE_W    = 24;
	localparam int SR_W       = 18;
	localparam int CPU_W      = 24;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int SPAN_W     = FREQ_W + 1;
	localparam int PROD_W     = SR_W + SPAN_W;

	// Parameter defaults
	localparam int WAVE_ENTRIES_DEF    = 32;
	localparam int PHASE_FRAC_BITS_DEF = 16;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_REG_READ  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_REG_WRITE = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_WAVE_WR   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_ADVANCE   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 3'd4;

	// Register addresses
	localparam logic [ADDR_W-1:0] ADDR_NR30 = 16'hFF1A;
	localparam logic [ADDR_W-1:0] ADDR_NR31 = 16'hFF1B;
	localparam logic [ADDR_W-1:0] ADDR_NR32 = 16'hFF1C;
	localparam logic [ADDR_W-1:0] ADDR_NR33 = 16'hFF1D;
	localparam logic [ADDR_W-1:0] ADDR_NR34 = 16'hFF1E;

	// Readback masks (unused bits read as one)
	localparam logic [BYTE_W-1:0] RB_MASK_NR30 = 8'h7F;
	localparam logic [BYTE_W-1:0] RB_MASK_NR32 = 8'h9F;
	localparam logic [BYTE_W-1:0] RB_MASK_NR34 = 8'hBF;
	localparam logic [BYTE_W-1:0] RB_UNMAPPED  = 8'hFF;

	// Frequency span: period is (FREQ_SPAN - freq)
	localparam logic [SPAN_W-1:0] FREQ_SPAN = 12'd2048;
	// Length units per register step
	localparam int LEN_STEPS  = 256;
	localparam int LEN_UNIT_SH = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_CLOCK   = 1'd1;

	localparam logic [SR_W-1:0]  SR_RESET  = 18'd44100;
	localparam logic [CPU_W-1:0] CPU_RESET = 24'd4194304;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [ADDR_W-1:0]   address;
		logic [SLOT_W-1:0]   wave_slot;
		logic [BYTE_W-1:0]   data_byte;
		logic [CYCLE_W-1:0]  cycle_count;
	} cmd_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic [BYTE_W-1:0] sample_out;
		logic              channel_on;
	} rsp_item_t;

endpackage

/* hdl/wsc_core.sv */
// ----------------------------------------------------------------------------
// wsc_core: channel state and per-item update
// Holds registers, wave table, length countdown and phase; forms one result
// per accepted item in the same cycle and updates state at the accept edge.
// ----------------------------------------------------------------------------
module wsc_core #(
	parameter int WAVE_ENTRIES    = wsc_pkg::WAVE_ENTRIES_DEF,
	parameter int PHASE_FRAC_BITS = wsc_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  wsc_pkg::cmd_item_t         cmd,
	input  logic                       cfg_we,
	input  logic [wsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsc_pkg::CFG_W-1:0]  cfg_data,
	output wsc_pkg::rsp_item_t         rsp,
	output logic                       thr_busy
);

	localparam int PW      = $clog2(WAVE_ENTRIES);
	localparam int THR_SH  = 21 - PHASE_FRAC_BITS;
	localparam int THR_W   = wsc_pkg::PROD_W - THR_SH;
	localparam int SUM_W   = ((THR_W > wsc_pkg::PHASE_W) ? THR_W : wsc_pkg::PHASE_W) + 2;
	localparam int SLOT_W_P1 = wsc_pkg::SLOT_W + 1;
	localparam logic [SUM_W-1:0] PHASE_ONE = SUM_W'(1) << PHASE_FRAC_BITS;
	localparam logic [SUM_W-1:0] PHASE_SAT = SUM_W'({wsc_pkg::PHASE_W{1'b1}});

	// Configuration
	logic [wsc_pkg::SR_W-1:0]  sample_rate_q;
	logic [wsc_pkg::CPU_W-1:0] cpu_clock_q;

	// Channel state
	logic                          rb_dac_q;
	logic [1:0]                    rb_vol_q;
	logic                          rb_len_q;
	logic                          dac_en_q;
	logic                          playing_q;
	logic [wsc_pkg::FREQ_W-1:0]    freq_q;
	logic [wsc_pkg::SHIFT_W-1:0]   level_shift_q;
	logic                          len_en_q;
	logic [wsc_pkg::LEN_W-1:0]     len_left_q;
	logic [PW-1:0]                 pos_q;
	logic [wsc_pkg::PHASE_W-1:0]   phase_q;
	logic [wsc_pkg::BYTE_W-1:0]    wave_q [WAVE_ENTRIES];
	logic [THR_W-1:0]              thr_q;
	logic                          dirty_q;

	// Next-state values
	logic                          rb_dac_d;
	logic [1:0]                    rb_vol_d;
	logic                          rb_len_d;
	logic                          dac_en_d;
	logic                          playing_d;
	logic [wsc_pkg::FREQ_W-1:0]    freq_d;
	logic [wsc_pkg::SHIFT_W-1:0]   level_shift_d;
	logic                          len_en_d;
	logic [wsc_pkg::LEN_W-1:0]     len_left_d;
	logic [PW-1:0]                 pos_d;
	logic [wsc_pkg::PHASE_W-1:0]   phase_d;
	logic                          wave_we;
	logic [wsc_pkg::BYTE_W-1:0]    rd_data;
	logic [wsc_pkg::BYTE_W-1:0]    smp_data;

	logic [wsc_pkg::SPAN_W-1:0]    span;
	logic [wsc_pkg::PROD_W-1:0]    thr_prod;
	logic [SUM_W-1:0]              phase_ext;
	logic [SUM_W-1:0]              thr_ext;
	logic [SUM_W-1:0]              phase_sum;
	logic                          phase_step;
	logic [PW-1:0]                 pos_step;
	logic [SLOT_W_P1-1:0]          slot2;
	logic [PW-1:0]                 idx_even;
	logic [PW-1:0]                 idx_odd;
	logic [8:0]                    len_mul_a;
	logic [wsc_pkg::LEN_W:0]       len_prod;
	logic [wsc_pkg::LEN_W-1:0]     cyc_ext;
	logic                          freq_write;

	// Threshold from registered frequency and sample rate
	assign span     = wsc_pkg::FREQ_SPAN - {1'b0, freq_q};
	assign thr_prod = wsc_pkg::PROD_W'(sample_rate_q) * wsc_pkg::PROD_W'(span);

	// Phase compare and step
	assign phase_ext  = SUM_W'(phase_q);
	assign thr_ext    = SUM_W'(thr_q);
	assign phase_step = phase_ext > thr_ext;
	assign phase_sum  = phase_step ? (phase_ext + PHASE_ONE - thr_ext)
	                               : (phase_ext + PHASE_ONE);
	assign pos_step   = phase_step ? pos_q + PW'(1) : pos_q;

	// Wave slot to entry pair
	assign slot2    = {cmd.wave_slot, 1'b0};
	assign idx_even = slot2[PW-1:0];
	assign idx_odd  = {idx_even[PW-1:1], 1'b1};

	// Length reload from NR31
	assign len_mul_a = 9'(wsc_pkg::LEN_STEPS) - {1'b0, cmd.data_byte};
	assign len_prod  = (wsc_pkg::LEN_W + 1)'(len_mul_a)
	                 * (wsc_pkg::LEN_W + 1)'(cpu_clock_q >> wsc_pkg::LEN_UNIT_SH);
	assign cyc_ext   = wsc_pkg::LEN_W'(cmd.cycle_count);

	assign freq_write = (cmd.opcode == wsc_pkg::OP_REG_WRITE)
	                 && ((cmd.address == wsc_pkg::ADDR_NR33)
	                  || (cmd.address == wsc_pkg::ADDR_NR34));

	// Decode one item
	always_comb begin
		rb_dac_d      = rb_dac_q;
		rb_vol_d      = rb_vol_q;
		rb_len_d      = rb_len_q;
		dac_en_d      = dac_en_q;
		playing_d     = playing_q;
		freq_d        = freq_q;
		level_shift_d = level_shift_q;
		len_en_d      = len_en_q;
		len_left_d    = len_left_q;
		pos_d         = pos_q;
		phase_d       = phase_q;
		wave_we       = 1'b0;
		rd_data       = '0;
		smp_data      = '0;
		unique case (cmd.opcode)
			wsc_pkg::OP_REG_READ: begin
				unique case (cmd.address)
					wsc_pkg::ADDR_NR30: rd_data = wsc_pkg::RB_MASK_NR30 | {rb_dac_q, 7'b0};
					wsc_pkg::ADDR_NR32: rd_data = wsc_pkg::RB_MASK_NR32 | {1'b0, rb_vol_q, 5'b0};
					wsc_pkg::ADDR_NR34: rd_data = wsc_pkg::RB_MASK_NR34 | {1'b0, rb_len_q, 6'b0};
					default:            rd_data = wsc_pkg::RB_UNMAPPED;
				endcase
			end
			wsc_pkg::OP_REG_WRITE: begin
				unique case (cmd.address)
					wsc_pkg::ADDR_NR30: begin
						rb_dac_d = cmd.data_byte[7];
						dac_en_d = cmd.data_byte[7];
						if (!cmd.data_byte[7]) begin
							playing_d = 1'b0;
						end
					end
					wsc_pkg::ADDR_NR31: begin
						len_left_d = len_prod[wsc_pkg::LEN_W-1:0];
					end
					wsc_pkg::ADDR_NR32: begin
						rb_vol_d = cmd.data_byte[6:5];
						unique case (cmd.data_byte[6:5])
							2'd0:    level_shift_d = 4'd8;
							2'd1:    level_shift_d = 4'd0;
							2'd2:    level_shift_d = 4'd4;
							default: level_shift_d = 4'd6;
						endcase
					end
					wsc_pkg::ADDR_NR33: begin
						freq_d = {freq_q[10:8], cmd.data_byte};
					end
					wsc_pkg::ADDR_NR34: begin
						freq_d   = {cmd.data_byte[2:0], freq_q[7:0]};
						len_en_d = cmd.data_byte[6];
						rb_len_d = cmd.data_byte[6];
						if (cmd.data_byte[7]) begin
							if (len_left_q == '0) begin
								len_left_d = cpu_clock_q;
							end
							pos_d     = '0;
							phase_d   = '0;
							playing_d = dac_en_q;
						end
					end
					default: ;
				endcase
			end
			wsc_pkg::OP_WAVE_WR: begin
				wave_we = 1'b1;
			end
			wsc_pkg::OP_ADVANCE: begin
				if (len_en_q && (len_left_q != '0)) begin
					if (len_left_q <= cyc_ext) begin
						len_left_d = '0;
						playing_d  = 1'b0;
					end else begin
						len_left_d = len_left_q - cyc_ext;
					end
				end
			end
			wsc_pkg::OP_SAMPLE: begin
				pos_d    = pos_step;
				phase_d  = (phase_sum > PHASE_SAT) ? wsc_pkg::PHASE_W'(PHASE_SAT)
				                                   : phase_sum[wsc_pkg::PHASE_W-1:0];
				smp_data = wave_q[pos_step] >> level_shift_q;
			end
			default: ;
		endcase
	end

	assign rsp.read_data  = rd_data;
	assign rsp.sample_out = smp_data;
	assign rsp.channel_on = playing_d;
	assign thr_busy       = dirty_q;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= wsc_pkg::SR_RESET;
			cpu_clock_q   <= wsc_pkg::CPU_RESET;
		end else if (cfg_we) begin
			if (cfg_index == wsc_pkg::CFG_SAMPLE_RATE) begin
				sample_rate_q <= cfg_data[wsc_pkg::SR_W-1:0];
			end
			if (cfg_index == wsc_pkg::CFG_CPU_CLOCK) begin
				cpu_clock_q <= cfg_data[wsc_pkg::CPU_W-1:0];
			end
		end
	end

	// Refresh threshold; flag one cycle where it is stale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			dirty_q <= 1'b1;
		end else begin
			thr_q   <= THR_W'(thr_prod >> THR_SH);
			dirty_q <= cfg_we || (accept && freq_write);
		end
	end

	// Commit channel state on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_dac_q      <= 1'b1;
			rb_vol_q      <= 2'b11;
			rb_len_q      <= 1'b1;
			dac_en_q      <= 1'b0;
			playing_q     <= 1'b0;
			freq_q        <= '0;
			level_shift_q <= '0;
			len_en_q      <= 1'b0;
			len_left_q    <= '0;
			pos_q         <= '0;
			phase_q       <= '0;
		end else if (accept) begin
			rb_dac_q      <= rb_dac_d;
			rb_vol_q      <= rb_vol_d;
			rb_len_q      <= rb_len_d;
			dac_en_q      <= dac_en_d;
			playing_q     <= playing_d;
			freq_q        <= freq_d;
			level_shift_q <= level_shift_d;
			len_en_q      <= len_en_d;
			len_left_q    <= len_left_d;
			pos_q         <= pos_d;
			phase_q       <= phase_d;
		end
	end

	// Wave table: reset pattern, nibble pair writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAVE_ENTRIES; i++) begin
				wave_q[i] <= ((i % 4) >= 2) ? 8'hFF : 8'h00;
			end
		end else if (accept && wave_we) begin
			wave_q[idx_even] <= {cmd.data_byte[7:4], 4'b0};
			wave_q[idx_odd]  <= {cmd.data_byte[3:0], 4'b0};
		end
	end

endmodule

/* hdl/wsc_skid.sv */
// ----------------------------------------------------------------------------
// wsc_skid: result register with one skid entry
// Holds results while the output side stalls and keeps the input side free until the skid entry fills.
// ----------------------------------------------------------------------------
module wsc_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wsc_pkg::rsp_item_t push_item,
	input  logic               rsp_stall,
	output logic               rsp_valid,
	output wsc_pkg::rsp_item_t rsp,
	output logic               full
);

	logic               out_valid_q;
	logic               skid_valid_q;
	wsc_pkg::rsp_item_t out_item_q;
	wsc_pkg::rsp_item_t skid_item_q;
	logic               out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_item_q;
	assign full      = skid_valid_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Move payload: skid drains first, else new item
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_item_q <= skid_item_q;
			end else if (push) begin
				out_item_q <= push_item;
			end
		end else if (push) begin
			skid_item_q <= push_item;
		end
	end

endmodule

/* hdl/wave_sound_channel.sv */
// ----------------------------------------------------------------------------
// wave_sound_channel: wave-table sound channel
// Output: each result is registered, or held in the skid entry while stalled.
// Throughput: one item per cycle; after a frequency write or a configuration
// write the input stalls while the registered phase threshold (one 18x12
// multiply) reloads. A full skid entry also stalls the input.
// Reset: asynchronous, clears all state but the result payload registers at once.
// ----------------------------------------------------------------------------
module wave_sound_channel #(
	parameter int WAVE_ENTRIES    = wsc_pkg::WAVE_ENTRIES_DEF,
	parameter int PHASE_FRAC_BITS = wsc_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  wsc_pkg::cmd_item_t            cmd,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output wsc_pkg::rsp_item_t            rsp,
	input  logic                          cfg_we,
	input  logic [wsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsc_pkg::CFG_W-1:0]     cfg_data
);

	logic               accept;
	logic               thr_busy;
	logic               skid_full;
	wsc_pkg::rsp_item_t rsp_next;

	assign cmd_stall = skid_full || thr_busy;
	assign accept    = cmd_valid && !cmd_stall;

	wsc_core #(
		.WAVE_ENTRIES   (WAVE_ENTRIES),
		.PHASE_FRAC_BITS(PHASE_FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp      (rsp_next),
		.thr_busy (thr_busy)
	);

	wsc_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(rsp_next),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp),
		.full     (skid_full)
	);

	// Skid entry only fills behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n) skid_full |-> rsp_valid)
		else $error("skid entry full without a result waiting");

	// A result is valid in the cycle after every accepted item
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> rsp_valid)
		else $error("accepted item produced no result");

	// Frequency write holds off the next item while the threshold reloads
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.opcode == wsc_pkg::OP_REG_WRITE)
		 && ((cmd.address == wsc_pkg::ADDR_NR33) || (cmd.address == wsc_pkg::ADDR_NR34)))
		|=> cmd_stall)
		else $error("item accepted with a stale threshold");

endmodule
